// ===== design/ifri_pkg.sv =====
// types and constants shared by the frame transform engine
package ifri_pkg;

   localparam int COMP_W  = 8;
   localparam int DIM_W   = 9;
   localparam int XFORM_W = 3;
   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } pixel_type;

   localparam logic [XFORM_W-1:0] XFORM_IDENTITY  = 3'd0;
   localparam logic [XFORM_W-1:0] XFORM_INVERT    = 3'd1;
   localparam logic [XFORM_W-1:0] XFORM_HFLIP     = 3'd2;
   localparam logic [XFORM_W-1:0] XFORM_VFLIP     = 3'd3;
   localparam logic [XFORM_W-1:0] XFORM_ROT_LEFT  = 3'd4;
   localparam logic [XFORM_W-1:0] XFORM_ROT_RIGHT = 3'd5;

   localparam logic [1:0] REG_TRANSFORM = 2'd0;
   localparam logic [1:0] REG_WIDTH     = 2'd1;
   localparam logic [1:0] REG_HEIGHT    = 2'd2;
   localparam logic [1:0] REG_MAX_VALUE = 2'd3;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

endpackage

// ===== design/image_flip_rotate_invert_core.sv =====
// frame transform engine top level: counters, address mapping, result register
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | operation, red/green/blue_in
//  rsp     | out       | rsp_valid/rsp_stall  | red/green/blue_out, out_row/col, last, status
//  csr     | in/out    | apb psel/penable     | transform, width, height, max_value
//
// a load is written to the store as it is taken; a fetch reads the store at its
// accepting edge, holds off the next beat in the read slot, then enters the result
// register; a result waiting under stall still lets the next beat be taken; a fetch
// then waits in the read slot, holding off further beats until that result leaves
// synchronous reset clears counters, frame state and configuration; the store holds no reset
// a write of width or height restarts the frame, of transform restarts read-out
module image_flip_rotate_invert_core
   import ifri_pkg::*;
#(
   parameter int MAX_SIDE = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic [COMP_W-1:0]   req_red_in,
   input  logic [COMP_W-1:0]   req_green_in,
   input  logic [COMP_W-1:0]   req_blue_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [COMP_W-1:0]   rsp_red_out,
   output logic [COMP_W-1:0]   rsp_green_out,
   output logic [COMP_W-1:0]   rsp_blue_out,
   output logic [7:0]          rsp_out_row,
   output logic [7:0]          rsp_out_col,
   output logic                rsp_last_pixel,
   output logic                rsp_status,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int POS_W  = $clog2(MAX_SIDE);
   localparam int ADDR_W = 2 * POS_W;
   localparam int CMP_W  = (POS_W + 1 > DIM_W) ? POS_W + 1 : DIM_W;

   // dimension minus one after clamping to 1..MAX_SIDE
   function automatic logic [POS_W-1:0] dim_last(input logic [DIM_W-1:0] raw);
      logic [CMP_W-1:0] ext;
      logic [CMP_W-1:0] dec;
      ext = CMP_W'(raw);
      dec = ext - CMP_W'(1);
      if (raw == '0) begin
         return '0;
      end else if (ext > CMP_W'(MAX_SIDE)) begin
         return POS_W'(MAX_SIDE - 1);
      end
      return dec[POS_W-1:0];
   endfunction

   // configuration registers
   logic [XFORM_W-1:0] transform_ff;
   logic [DIM_W-1:0]   image_width_ff;
   logic [DIM_W-1:0]   image_height_ff;
   logic [COMP_W-1:0]  max_value_ff;

   logic       cfg_wr;
   logic [1:0] cfg_idx;

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (cfg_idx)
         REG_TRANSFORM: csr_prdata = CSR_DW'(transform_ff);
         REG_WIDTH:     csr_prdata = CSR_DW'(image_width_ff);
         REG_HEIGHT:    csr_prdata = CSR_DW'(image_height_ff);
         REG_MAX_VALUE: csr_prdata = CSR_DW'(max_value_ff);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         transform_ff    <= XFORM_IDENTITY;
         image_width_ff  <= DIM_W'(256);
         image_height_ff <= DIM_W'(256);
         max_value_ff    <= COMP_W'(255);
      end else if (cfg_wr) begin
         unique case (cfg_idx)
            REG_TRANSFORM: transform_ff    <= csr_pwdata[XFORM_W-1:0];
            REG_WIDTH:     image_width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_HEIGHT:    image_height_ff <= csr_pwdata[DIM_W-1:0];
            REG_MAX_VALUE: max_value_ff    <= csr_pwdata[COMP_W-1:0];
            default:       max_value_ff    <= max_value_ff;
         endcase
      end
   end

   // derived geometry
   logic [POS_W-1:0] w_m1, h_m1, ow_m1, oh_m1;
   logic             rotated;

   assign w_m1    = dim_last(image_width_ff);
   assign h_m1    = dim_last(image_height_ff);
   assign rotated = (transform_ff == XFORM_ROT_LEFT) || (transform_ff == XFORM_ROT_RIGHT);
   assign ow_m1   = rotated ? h_m1 : w_m1;
   assign oh_m1   = rotated ? w_m1 : h_m1;

   // position counters and frame state
   logic [POS_W-1:0] load_row_ff, load_col_ff, read_row_ff, read_col_ff;
   logic [POS_W-1:0] load_row_in, load_col_in, read_row_in, read_col_in;
   logic             frame_full_ff, frame_full_in;

   // fetch in flight and result register
   logic             pend_ff, pend_in;
   logic             pend_status_ff;
   logic             pend_last_ff;
   logic [7:0]       pend_row_ff, pend_col_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [COMP_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic [7:0]       rsp_row_ff, rsp_col_ff;
   logic             rsp_last_ff, rsp_status_ff;

   logic req_take, load_take, fetch_take, fetch_ok, pend_move, last_hit;

   assign req_stall  = pend_ff;
   assign req_take   = req_valid & ~req_stall;
   assign load_take  = req_take & (req_operation == OP_LOAD) & ~frame_full_ff;
   assign fetch_take = req_take & (req_operation == OP_FETCH);
   assign fetch_ok   = fetch_take & frame_full_ff;
   assign pend_move  = pend_ff & (~rsp_valid_ff | ~rsp_stall);
   assign last_hit   = (read_row_ff == oh_m1) && (read_col_ff == ow_m1);

   // source coordinates of the current output pixel
   logic [POS_W-1:0] src_row, src_col;

   always_comb begin
      unique case (transform_ff)
         XFORM_HFLIP: begin
            src_row = read_row_ff;
            src_col = w_m1 - read_col_ff;
         end
         XFORM_VFLIP: begin
            src_row = h_m1 - read_row_ff;
            src_col = read_col_ff;
         end
         XFORM_ROT_LEFT: begin
            src_row = read_col_ff;
            src_col = w_m1 - read_row_ff;
         end
         XFORM_ROT_RIGHT: begin
            src_row = h_m1 - read_col_ff;
            src_col = read_row_ff;
         end
         default: begin
            src_row = read_row_ff;
            src_col = read_col_ff;
         end
      endcase
   end

   pixel_type wr_pixel, rd_pixel;

   assign wr_pixel = '{red: req_red_in, green: req_green_in, blue: req_blue_in};

   ifri_frame_ram #(
      .ADDR_W (ADDR_W)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (load_take),
      .wr_addr ({load_row_ff, load_col_ff}),
      .wr_data (wr_pixel),
      .rd_en   (fetch_ok),
      .rd_addr ({src_row, src_col}),
      .rd_data (rd_pixel)
   );

   always_comb begin
      load_row_in   = load_row_ff;
      load_col_in   = load_col_ff;
      read_row_in   = read_row_ff;
      read_col_in   = read_col_ff;
      frame_full_in = frame_full_ff;
      priority if (cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT)) begin
         load_row_in   = '0;
         load_col_in   = '0;
         read_row_in   = '0;
         read_col_in   = '0;
         frame_full_in = 1'b0;
      end else if (cfg_wr && cfg_idx == REG_TRANSFORM) begin
         read_row_in = '0;
         read_col_in = '0;
      end else if (load_take) begin
         if (load_col_ff == w_m1) begin
            load_col_in = '0;
            if (load_row_ff == h_m1) begin
               load_row_in   = '0;
               frame_full_in = 1'b1;
            end else begin
               load_row_in = load_row_ff + POS_W'(1);
            end
         end else begin
            load_col_in = load_col_ff + POS_W'(1);
         end
      end else if (fetch_ok) begin
         if (last_hit) begin
            load_row_in   = '0;
            load_col_in   = '0;
            read_row_in   = '0;
            read_col_in   = '0;
            frame_full_in = 1'b0;
         end else if (read_col_ff == ow_m1) begin
            read_col_in = '0;
            read_row_in = read_row_ff + POS_W'(1);
         end else begin
            read_col_in = read_col_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_row_ff   <= '0;
         load_col_ff   <= '0;
         read_row_ff   <= '0;
         read_col_ff   <= '0;
         frame_full_ff <= 1'b0;
      end else begin
         load_row_ff   <= load_row_in;
         load_col_ff   <= load_col_in;
         read_row_ff   <= read_row_in;
         read_col_ff   <= read_col_in;
         frame_full_ff <= frame_full_in;
      end
   end

   // output coordinates, low eight bits
   logic [POS_W+7:0] row_ext, col_ext;

   assign row_ext = {8'b0, read_row_ff};
   assign col_ext = {8'b0, read_col_ff};

   assign pend_in      = fetch_take | (pend_ff & ~pend_move);
   assign rsp_valid_in = pend_move | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_take) begin
         pend_status_ff <= frame_full_ff ? STATUS_OK : STATUS_NOT_READY;
         pend_last_ff   <= frame_full_ff & last_hit;
         pend_row_ff    <= frame_full_ff ? row_ext[7:0] : 8'd0;
         pend_col_ff    <= frame_full_ff ? col_ext[7:0] : 8'd0;
      end
   end

   // inversion and result register
   pixel_type px_out;

   always_comb begin
      px_out = rd_pixel;
      if (pend_status_ff == STATUS_NOT_READY) begin
         px_out = '0;
      end else if (transform_ff == XFORM_INVERT) begin
         px_out.red   = max_value_ff - rd_pixel.red;
         px_out.green = max_value_ff - rd_pixel.green;
         px_out.blue  = max_value_ff - rd_pixel.blue;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_red_ff    <= px_out.red;
         rsp_green_ff  <= px_out.green;
         rsp_blue_ff   <= px_out.blue;
         rsp_row_ff    <= pend_row_ff;
         rsp_col_ff    <= pend_col_ff;
         rsp_last_ff   <= pend_last_ff;
         rsp_status_ff <= pend_status_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_red_out    = rsp_red_ff;
   assign rsp_green_out  = rsp_green_ff;
   assign rsp_blue_out   = rsp_blue_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_last_pixel = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

   // load position stays inside the source frame
   a_load_in_frame: assert property (@(posedge clock) disable iff (reset)
      (load_row_ff <= h_m1) && (load_col_ff <= w_m1))
      else $error("load position outside frame");

   // read position stays inside the output frame
   a_read_in_frame: assert property (@(posedge clock) disable iff (reset)
      (read_row_ff <= oh_m1) && (read_col_ff <= ow_m1))
      else $error("read position outside frame");

   // an accepted fetch always leaves a read in flight
   a_fetch_pending: assert property (@(posedge clock) disable iff (reset)
      fetch_take |=> pend_ff)
      else $error("fetch lost");

   // a read in flight is held while the result register is blocked
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp_valid_ff && rsp_stall) |=> pend_ff)
      else $error("pending beat dropped");

   // no beat is taken while a read is in flight
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_take)
      else $error("beat taken during read");

endmodule

// ===== design/ifri_frame_ram.sv =====
// frame store: one write port, one registered read port
module ifri_frame_ram
   import ifri_pkg::*;
#(
   parameter int ADDR_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pixel_type         rd_data
);

   pixel_type mem [0:(1<<ADDR_W)-1];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/ifri_checker.sv =====
// checker for the frame transform engine: tracks the frame, predicts each result beat, compares
module frame_xform_checker
   import ifri_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_operation,
   input  logic [COMP_W-1:0]   req_red_in,
   input  logic [COMP_W-1:0]   req_green_in,
   input  logic [COMP_W-1:0]   req_blue_in,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [COMP_W-1:0]   rsp_red_out,
   input  logic [COMP_W-1:0]   rsp_green_out,
   input  logic [COMP_W-1:0]   rsp_blue_out,
   input  logic [7:0]          rsp_out_row,
   input  logic [7:0]          rsp_out_col,
   input  logic                rsp_last_pixel,
   input  logic                rsp_status,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   input  logic                csr_pready,
   output int                  mismatches,
   output int                  results_waiting,
   output int                  results_checked
);

   localparam int SIDE = 256;

   typedef struct packed {
      pixel_type  px;
      logic [7:0] row;
      logic [7:0] col;
      logic       last;
      logic       status;
   } out_beat_type;

   pixel_type          frame_px [SIDE*SIDE];
   int                 load_r, load_c, read_r, read_c;
   bit                 full;
   logic [XFORM_W-1:0] xform;
   logic [DIM_W-1:0]   width_reg, height_reg;
   logic [COMP_W-1:0]  max_val;
   out_beat_type       pixel_q [$];

   function automatic int clamp_side(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > SIDE) return SIDE;
      return int'(v);
   endfunction

   task automatic restart_frame();
      load_r = 0;
      load_c = 0;
      read_r = 0;
      read_c = 0;
      full   = 1'b0;
   endtask

   task automatic write_register(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] value);
      case (addr[CSR_AW-1:2])
         REG_TRANSFORM: begin
            xform  = value[XFORM_W-1:0];
            read_r = 0;
            read_c = 0;
         end
         REG_WIDTH: begin
            width_reg = value[DIM_W-1:0];
            restart_frame();
         end
         REG_HEIGHT: begin
            height_reg = value[DIM_W-1:0];
            restart_frame();
         end
         REG_MAX_VALUE: max_val = value[COMP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic take_request(logic op, pixel_type px);
      int           w, h, ow, oh, sr, sc;
      bit           turned;
      pixel_type    src;
      out_beat_type beat;
      w      = clamp_side(width_reg);
      h      = clamp_side(height_reg);
      turned = (xform == XFORM_ROT_LEFT) || (xform == XFORM_ROT_RIGHT);
      ow     = turned ? h : w;
      oh     = turned ? w : h;
      beat   = '0;
      if (op == OP_LOAD) begin
         if (full) return;
         if (load_r >= h || load_c >= w) restart_frame();
         frame_px[load_r*SIDE + load_c] = px;
         load_c++;
         if (load_c >= w) begin
            load_c = 0;
            load_r++;
            if (load_r >= h) begin
               load_r = 0;
               full   = 1'b1;
            end
         end
         return;
      end
      if (!full) begin
         beat.status = STATUS_NOT_READY;
         pixel_q.push_back(beat);
         return;
      end
      if (read_r >= oh || read_c >= ow) begin
         read_r = 0;
         read_c = 0;
      end
      case (xform)
         XFORM_HFLIP: begin
            sr = read_r;
            sc = w - 1 - read_c;
         end
         XFORM_VFLIP: begin
            sr = h - 1 - read_r;
            sc = read_c;
         end
         XFORM_ROT_LEFT: begin
            sr = read_c;
            sc = w - 1 - read_r;
         end
         XFORM_ROT_RIGHT: begin
            sr = h - 1 - read_c;
            sc = read_r;
         end
         default: begin
            sr = read_r;
            sc = read_c;
         end
      endcase
      src = frame_px[sr*SIDE + sc];
      if (xform == XFORM_INVERT) begin
         src.red   = max_val - src.red;
         src.green = max_val - src.green;
         src.blue  = max_val - src.blue;
      end
      beat.px     = src;
      beat.row    = 8'(read_r);
      beat.col    = 8'(read_c);
      beat.last   = (read_r == oh - 1) && (read_c == ow - 1);
      beat.status = STATUS_OK;
      pixel_q.push_back(beat);
      if (beat.last) begin
         restart_frame();
      end else begin
         read_c++;
         if (read_c >= ow) begin
            read_c = 0;
            read_r++;
         end
      end
   endtask

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      out_beat_type want;
      if (reset) begin
         pixel_q.delete();
         restart_frame();
         xform      = XFORM_IDENTITY;
         width_reg  = DIM_W'(SIDE);
         height_reg = DIM_W'(SIDE);
         max_val    = '1;
      end else begin
         // results first: a fetch taken at this edge cannot answer at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               $error("result beat arrived with nothing expected");
               mismatches++;
            end else begin
               want = pixel_q.pop_front();
               compare_field("red_out", want.px.red, rsp_red_out);
               compare_field("green_out", want.px.green, rsp_green_out);
               compare_field("blue_out", want.px.blue, rsp_blue_out);
               compare_field("out_row", want.row, rsp_out_row);
               compare_field("out_col", want.col, rsp_out_col);
               compare_field("last_pixel", 8'(want.last), 8'(rsp_last_pixel));
               compare_field("status", 8'(want.status), 8'(rsp_status));
               results_checked++;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            write_register(csr_paddr, csr_pwdata);
         if (req_valid && !req_stall)
            take_request(req_operation, {req_red_in, req_green_in, req_blue_in});
      end
      results_waiting = pixel_q.size();
   end

endmodule

// ===== tb/tb.sv =====
// testbench top for the frame transform engine: clock, reset, stimulus and verdict
module tb
   import ifri_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1950;
   localparam logic [XFORM_W-1:0] XFORM_SPARE_A = 3'd6;
   localparam logic [XFORM_W-1:0] XFORM_SPARE_B = 3'd7;

   typedef enum int {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_type;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic                req_operation = OP_LOAD;
   logic [COMP_W-1:0]   req_red_in    = '0;
   logic [COMP_W-1:0]   req_green_in  = '0;
   logic [COMP_W-1:0]   req_blue_in   = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic [COMP_W-1:0]   rsp_red_out, rsp_green_out, rsp_blue_out;
   logic [7:0]          rsp_out_row, rsp_out_col;
   logic                rsp_last_pixel, rsp_status;
   logic                csr_psel      = 1'b0;
   logic                csr_penable   = 1'b0;
   logic                csr_pwrite    = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr     = '0;
   logic [CSR_DW-1:0]   csr_pwdata    = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   int             mismatches, results_waiting, results_checked;
   int             cycle_count    = 0;
   int             items_sent     = 0;
   int             settings_used  = 0;
   int             burst_left     = 0;
   int             stall_span     = 0;
   stall_mode_type stall_mode     = STALL_NONE;

   image_flip_rotate_invert_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_red_in     (req_red_in),
      .req_green_in   (req_green_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_last_pixel (rsp_last_pixel),
      .rsp_status     (rsp_status),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   frame_xform_checker xform_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_pixel  (rsp_last_pixel),
      .rsp_status      (rsp_status),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatches      (mismatches),
      .results_waiting (results_waiting),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("tb failed");
      $finish;
   end

   // result side back-pressure, switching pattern every so often
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_span <= $urandom_range(16, 256);
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= (cycle_count % 3 == 0);
      endcase
   end

   function automatic int side_of(logic [DIM_W-1:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return int'(v);
   endfunction

   function automatic pixel_type rand_pixel();
      pixel_type px;
      px = pixel_type'(24'($urandom()));
      case ($urandom_range(0, 7))
         0: px = '0;
         1: px = '1;
         default: ;
      endcase
      return px;
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic push_item(logic op, pixel_type px, bit counted);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_red_in    <= px.red;
      req_green_in  <= px.green;
      req_blue_in   <= px.blue;
      do @(posedge clock); while (req_stall);
      if (counted) items_sent++;
   endtask

   // quiet the sender and let every result and any load still in flight finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_regs(logic [XFORM_W-1:0] xf, logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                           logic [COMP_W-1:0] mv);
      settle();
      csr_write(REG_WIDTH, CSR_DW'(w));
      csr_write(REG_HEIGHT, CSR_DW'(h));
      csr_write(REG_TRANSFORM, CSR_DW'(xf));
      csr_write(REG_MAX_VALUE, CSR_DW'(mv));
      settings_used++;
   endtask

   task automatic load_frame(int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) push_item(OP_FETCH, rand_pixel(), 1);
         push_item(OP_LOAD, rand_pixel(), 1);
      end
      // frame is full now, these loads must be dropped
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_item(OP_LOAD, rand_pixel(), 0);
   endtask

   task automatic fetch_run(int n);
      repeat (n) push_item(OP_FETCH, rand_pixel(), 1);
   endtask

   task automatic pick_dims(output logic [DIM_W-1:0] w, output logic [DIM_W-1:0] h);
      case ($urandom_range(0, 47))
         0: begin w = 256; h = 1; end
         1: begin w = 1; h = 256; end
         2: begin w = DIM_W'($urandom_range(257, 511)); h = 1; end
         3: begin w = 1; h = DIM_W'($urandom_range(257, 511)); end
         4: begin w = 0; h = DIM_W'($urandom_range(0, 4)); end
         5: begin w = DIM_W'($urandom_range(0, 4)); h = 0; end
         default: begin
            w = DIM_W'($urandom_range(1, 8));
            h = DIM_W'($urandom_range(1, 8));
         end
      endcase
   endtask

   task automatic run_phase();
      logic [DIM_W-1:0] w, h;
      int               n;
      pick_dims(w, h);
      set_regs(XFORM_W'($urandom_range(0, 7)), w, h, COMP_W'($urandom_range(0, 255)));
      n = side_of(w) * side_of(h);
      if ($urandom_range(0, 6) == 0) begin
         // broken order: loads and fetches mixed at random
         repeat ($urandom_range(1, 2*n + 2))
            push_item($urandom_range(0, 1) ? OP_FETCH : OP_LOAD, rand_pixel(), 1);
         return;
      end
      load_frame(n);
      if ($urandom_range(0, 4) == 0) begin
         // part of the read-out, then a new transform restarts it on the same frame
         fetch_run($urandom_range(0, n - 1));
         settle();
         csr_write(REG_TRANSFORM, CSR_DW'($urandom_range(0, 7)));
         csr_write(REG_MAX_VALUE, CSR_DW'($urandom_range(0, 255)));
         settings_used++;
      end
      fetch_run(n);
      if ($urandom_range(0, 4) == 0) push_item(OP_FETCH, rand_pixel(), 1);
   endtask

   initial begin : stimulus
      int items_goal;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fetch on an empty frame, then a 2x2 frame with all-zero, all-one and alternating bit patterns
      push_item(OP_FETCH, 24'h000000, 1);
      set_regs(XFORM_IDENTITY, 2, 2, 8'hFF);
      push_item(OP_LOAD, 24'h000000, 1);
      push_item(OP_LOAD, 24'hFFFFFF, 1);
      push_item(OP_FETCH, 24'hFFFFFF, 1);
      push_item(OP_LOAD, 24'hAA550F, 1);
      push_item(OP_LOAD, 24'h55AAF0, 1);
      push_item(OP_LOAD, 24'h123456, 0);
      push_item(OP_FETCH, 24'h000000, 1);
      push_item(OP_FETCH, 24'h000000, 1);
      // inversion with a small maximum wraps; transform write restarts read-out
      settle();
      csr_write(REG_TRANSFORM, CSR_DW'(XFORM_INVERT));
      csr_write(REG_MAX_VALUE, CSR_DW'(8'h0F));
      settings_used++;
      fetch_run(4);
      push_item(OP_FETCH, 24'hFFFFFF, 1);
      // spare transform codes, zero sizes, zero maximum
      set_regs(XFORM_SPARE_A, 1, 1, 8'h01);
      push_item(OP_LOAD, 24'hC3A5E7, 1);
      push_item(OP_FETCH, 24'h000000, 1);
      set_regs(XFORM_SPARE_B, 0, 0, 8'h00);
      push_item(OP_LOAD, 24'h3C5A18, 1);
      push_item(OP_FETCH, 24'h000000, 1);

      items_goal = items_sent + RANDOM_ITEMS;
      while (items_sent < items_goal) run_phase();

      settle();
      repeat (16) @(posedge clock);
      if (results_waiting != 0) $error("%0d expected results never arrived", results_waiting);
      $display("%0d beats sent and %0d results compared over %0d register settings",
               items_sent, results_checked, settings_used);
      if (mismatches == 0 && results_waiting == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
